>>> src/pse_pkg.sv
`default_nettype none
package pse_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned CMD_W  = 3;
	localparam int unsigned STAT_W = 3;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [CMD_W-1:0]  cmd_t;
	typedef logic [STAT_W-1:0] status_t;

	localparam cmd_t CMD_PUSH = 3'd0;
	localparam cmd_t CMD_ADD  = 3'd1;
	localparam cmd_t CMD_SUB  = 3'd2;
	localparam cmd_t CMD_MUL  = 3'd3;
	localparam cmd_t CMD_DIV  = 3'd4;
	localparam cmd_t CMD_REM  = 3'd5;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_UNDERFLOW = 3'd1;
	localparam status_t ST_LEFTOVER  = 3'd2;
	localparam status_t ST_DIVZERO   = 3'd3;
	localparam status_t ST_OVERFLOW  = 3'd4;

endpackage
`default_nettype wire

>>> src/postfix_stack_evaluator_core.sv
// sequence per token: a push or ignored token goes from idle to the final state; add/sub/mul
// fetch the left operand, then finish; divide/remainder fetch, run the 32-step shift-subtract divider
// and the sign fixup, then finish; the last token's result is registered in the final cycle of its beat.
// tokens do not overlap: a new token is taken only back in idle; stack fetch uses one memory read port.
// reset (arst_n low): clears sequencer, stack count, error code and output valid;
// stack memory contents are not cleared, only entries below the count are ever read.
`default_nettype none
module postfix_stack_evaluator_core
	import pse_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire logic [2:0]         cmd,
	input  wire logic signed [31:0] operand_value,
	input  wire logic               last_token,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      logic signed [31:0] result_value,
	output      logic [2:0]         status
);

	// stack entry count needs to hold STACK_DEPTH itself, addresses do not
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned AW = $clog2(STACK_DEPTH);

	// sequencer codes
	localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a token beat
	localparam logic [2:0] S_RD   = 3'd1;  // left operand arrives from memory
	localparam logic [2:0] S_DIV  = 3'd2;  // one quotient bit per cycle
	localparam logic [2:0] S_FIX  = 3'd3;  // sign fixup of quotient or remainder
	localparam logic [2:0] S_FIN  = 3'd4;  // end of token, emit result on last

	logic [2:0]    state_q;
	logic [CW-1:0] cnt_q;
	status_t       err_q;
	cmd_t          cmd_q;
	logic          last_q;
	logic [4:0]    step_q;

	// the top of stack lives in a register, entries below it in memory,
	// so an operator needs only one memory read
	word_t top_q;
	word_t rd_q;
	word_t stack_mem [STACK_DEPTH];

	// divider registers
	word_t rem_q;
	word_t quo_q;
	word_t dvs_q;
	logic  negq_q;
	logic  negr_q;

	// output register
	logic    out_valid_q;
	word_t   result_q;
	status_t status_q;

	// token decode in idle
	logic    acc;
	logic    skip;
	logic    is_push;
	logic    is_op;
	logic    ovf;
	logic    und;
	logic    dz;
	logic    push_ok;
	logic    op_go;

	// memory ports
	logic          mem_we;
	logic [CW-1:0] waddr_full;
	logic [CW-1:0] raddr_full;
	logic [AW-1:0] mem_waddr;
	logic [AW-1:0] mem_raddr;

	// datapath
	word_t   alu_res;
	word_t   abs_a;
	word_t   abs_b;
	logic [WORD_W:0] trial;
	word_t   fix_res;
	logic    fin_load;
	word_t   fin_value;
	status_t fin_status;

	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid && in_ready;

	always_comb begin
		is_push = 1'b0;
		is_op   = 1'b0;
		case (cmd)
			CMD_PUSH: is_push = 1'b1;
			CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_REM: is_op = 1'b1;
			default: begin
				// unused codes leave the stack alone
				is_push = 1'b0;
				is_op   = 1'b0;
			end
		endcase
	end

	// a pending error freezes the rest of the expression
	assign skip    = (err_q != ST_OK);
	assign ovf     = acc && !skip && is_push && (cnt_q >= CW'(STACK_DEPTH));
	assign push_ok = acc && !skip && is_push && !ovf;
	assign und     = acc && !skip && is_op && (cnt_q < CW'(2));
	assign dz      = acc && !skip && is_op && !und && (cmd inside {CMD_DIV, CMD_REM})
	                 && (top_q == '0);
	assign op_go   = acc && !skip && is_op && !und && !dz;

	// push spills the old top into memory; operator fetches the entry below the top
	assign waddr_full = cnt_q - CW'(1);
	assign raddr_full = cnt_q - CW'(2);
	assign mem_waddr  = waddr_full[AW-1:0];
	assign mem_raddr  = raddr_full[AW-1:0];
	assign mem_we     = push_ok && (cnt_q != '0);

	// add, subtract, multiply on rd_q (left) and top_q (right)
	always_comb begin
		case (cmd_q)
			CMD_ADD: alu_res = rd_q + top_q;
			CMD_SUB: alu_res = rd_q - top_q;
			CMD_MUL: alu_res = rd_q * top_q;
			default: alu_res = '0;
		endcase
	end

	assign abs_a = rd_q[WORD_W-1]  ? (word_t'(0) - rd_q)  : rd_q;
	assign abs_b = top_q[WORD_W-1] ? (word_t'(0) - top_q) : top_q;

	// restoring division step: shift in next dividend bit, try subtract
	assign trial = {rem_q, quo_q[WORD_W-1]} - {1'b0, dvs_q};

	always_comb begin
		if (cmd_q == CMD_DIV) begin
			fix_res = negq_q ? (word_t'(0) - quo_q) : quo_q;
		end else begin
			fix_res = negr_q ? (word_t'(0) - rem_q) : rem_q;
		end
	end

	// final report: a sticky error wins, then the stack must hold exactly one value
	always_comb begin
		fin_value = '0;
		if (err_q != ST_OK) begin
			fin_status = err_q;
		end else if (cnt_q == '0) begin
			fin_status = ST_UNDERFLOW;
		end else if (cnt_q != CW'(1)) begin
			fin_status = ST_LEFTOVER;
		end else begin
			fin_status = ST_OK;
			fin_value  = top_q;
		end
	end

	assign fin_load = (state_q == S_FIN) && last_q && (!out_valid_q || out_ready);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			err_q       <= ST_OK;
			cmd_q       <= CMD_PUSH;
			last_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result beat may take the place of one leaving this cycle
			if (fin_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						cmd_q  <= cmd;
						last_q <= last_token;
						if (ovf) begin
							err_q <= ST_OVERFLOW;
						end
						if (und) begin
							err_q <= ST_UNDERFLOW;
						end
						if (dz) begin
							err_q <= ST_DIVZERO;
						end
						if (push_ok) begin
							cnt_q <= cnt_q + CW'(1);
						end
						state_q <= op_go ? S_RD : S_FIN;
					end
				end
				S_RD: begin
					if (cmd_q inside {CMD_DIV, CMD_REM}) begin
						step_q  <= '0;
						state_q <= S_DIV;
					end else begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= S_FIN;
					end
				end
				S_DIV: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'd31) begin
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					cnt_q   <= cnt_q - CW'(1);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (fin_load) begin
						// expression done: report and start fresh
						cnt_q   <= '0;
						err_q   <= ST_OK;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// stack memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_waddr] <= top_q;
		end
		if (op_go) begin
			rd_q <= stack_mem[mem_raddr];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (push_ok) begin
					top_q <= word_t'(operand_value);
				end
			end
			S_RD: begin
				if (cmd_q inside {CMD_DIV, CMD_REM}) begin
					rem_q  <= '0;
					quo_q  <= abs_a;
					dvs_q  <= abs_b;
					negq_q <= rd_q[WORD_W-1] ^ top_q[WORD_W-1];
					negr_q <= rd_q[WORD_W-1];
				end else begin
					top_q <= alu_res;
				end
			end
			S_DIV: begin
				if (!trial[WORD_W]) begin
					rem_q <= trial[WORD_W-1:0];
					quo_q <= {quo_q[WORD_W-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[WORD_W-2:0], quo_q[WORD_W-1]};
					quo_q <= {quo_q[WORD_W-2:0], 1'b0};
				end
			end
			S_FIX: begin
				top_q <= fix_res;
			end
			default: begin
			end
		endcase
		if (fin_load) begin
			result_q <= fin_value;
			status_q <= fin_status;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = signed'(result_q);
	assign status       = status_q;

endmodule
`default_nettype wire

>>> src/pse_checker.sv
`default_nettype none
module pse_checker
	import pse_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic [2:0]         cmd,
	input wire logic signed [31:0] operand_value,
	input wire logic               last_token,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic signed [31:0] result_value,
	input wire logic [2:0]         status
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(status))
		else $error("result beat changed while stalled");

	// any failure reports a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |-> (result_value == 32'sd0))
		else $error("non-ok status with nonzero value");

	// an accepted token leaves the sequencer busy in the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("token accepted back to back");

	// only defined status codes leave the block
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_OK) || (status == ST_UNDERFLOW) ||
		(status == ST_LEFTOVER) || (status == ST_DIVZERO) || (status == ST_OVERFLOW))
		else $error("undefined status code");

endmodule

bind postfix_stack_evaluator_core pse_checker u_pse_checker (.*);
`default_nettype wire
